FILE: sv/one_at_a_time_hash_bucket_macros.svh
// Assertion macros used by the checker file of the bucket hash block.
// No dependencies; the including file supplies clock and reset names.
`ifndef ONE_AT_A_TIME_HASH_BUCKET_MACROS_SVH
`define ONE_AT_A_TIME_HASH_BUCKET_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define OAAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oaat assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define OAAT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oaat assertion failed: next-cycle implication");

`endif

FILE: sv/oaat_pkg.sv
// Package of the one-at-a-time bucket hash block: widths, constants, types.
// Used by the interfaces, the remainder unit and the top level.
package oaat_pkg;

    localparam int HASH_W = 64;
    localparam int SLOT_W = 32;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = $clog2(HASH_W);

    localparam logic [SLOT_W-1:0] SLOTS_RESET = SLOT_W'(1024);

    // Shift amounts of the mixing and finalization rounds.
    localparam int SHL_MIX = 10;
    localparam int SHR_MIX = 6;
    localparam int SHL_FIN_A = 3;
    localparam int SHR_FIN = 11;
    localparam int SHL_FIN_B = 15;

    // Step codes of the shared add/xor unit.
    typedef logic [2:0] t_step;
    localparam t_step STEP_ADD_BYTE = 3'd0;
    localparam t_step STEP_MIX_SHL  = 3'd1;
    localparam t_step STEP_MIX_SHR  = 3'd2;
    localparam t_step STEP_FIN_SHLA = 3'd3;
    localparam t_step STEP_FIN_SHR  = 3'd4;
    localparam t_step STEP_FIN_SHLB = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MIX  = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_PUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [SLOT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rem;
    } t_div_rsp;

endpackage

FILE: sv/oaat_if.sv
// Valid/ready channel interfaces for key bytes in and bucket indexes out.
// Depends on oaat_pkg for the field widths.
interface oaat_in_if import oaat_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] key_byte;
    logic              byte_valid;
    logic              last_byte;

    modport source (output valid, key_byte, byte_valid, last_byte, input ready);
    modport sink   (input valid, key_byte, byte_valid, last_byte, output ready);
endinterface

interface oaat_out_if import oaat_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] bucket_index;

    modport source (output valid, bucket_index, input ready);
    modport sink   (input valid, bucket_index, output ready);
endinterface

FILE: sv/oaat_mod.sv
// Restoring remainder unit: final hash modulo slot count, one bit per cycle.
// Depends on oaat_pkg for widths and the request/response structs.
module oaat_mod import oaat_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [HASH_W-1:0] r_dvd;
    logic [SLOT_W-1:0] r_div;
    logic [SLOT_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [SLOT_W:0]   trial;
    logic [SLOT_W:0]   diff;
    logic [SLOT_W-1:0] n_rem;

    assign trial = {r_rem, r_dvd[HASH_W-1]};
    assign diff  = trial - {1'b0, r_div};
    // The remainder stays below the divisor, so the kept value fits SLOT_W bits.
    assign n_rem = (trial >= {1'b0, r_div}) ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(HASH_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[HASH_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: sv/one_at_a_time_hash_bucket.sv
// Jenkins one-at-a-time hash of a byte stream, reduced to a bucket index.
// A key byte is taken on accept and then runs three add/xor steps (add byte, mix left,
// mix right); an item with no byte and no last mark is absorbed on accept. The last item
// adds three finalization steps, a load, the bit-serial remainder, the done strobe and the
// hand-off, which waits while an untaken result is held; then the next item is taken.
// Synchronous active-low reset clears the sequencer, the hash and sets 1024 slots.
module one_at_a_time_hash_bucket import oaat_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SLOT_W-1:0] i_cfg_wdata,
    oaat_in_if.sink           i_in,
    oaat_out_if.source        o_out
);

    t_state            r_state, n_state;
    t_step             r_step, n_step;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [SLOT_W-1:0] r_slots;
    logic              r_ov;
    logic [SLOT_W-1:0] r_bucket;

    logic              in_acc;
    logic              out_free;
    logic [HASH_W-1:0] operand;
    logic              use_xor;
    logic [HASH_W-1:0] step_res;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign i_in.ready = i_rst_n && (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_ov || o_out.ready;

    // Shared unit: one wide add or xor of the hash with the key byte or a shifted copy per cycle.
    always_comb begin
        operand = '0;
        use_xor = 1'b0;
        case (r_step)
            STEP_ADD_BYTE: operand = {{(HASH_W-BYTE_W){1'b0}}, r_byte};
            STEP_MIX_SHL:  operand = r_hash << SHL_MIX;
            STEP_MIX_SHR: begin
                operand = r_hash >> SHR_MIX;
                use_xor = 1'b1;
            end
            STEP_FIN_SHLA: operand = r_hash << SHL_FIN_A;
            STEP_FIN_SHR: begin
                operand = r_hash >> SHR_FIN;
                use_xor = 1'b1;
            end
            STEP_FIN_SHLB: operand = r_hash << SHL_FIN_B;
            default:       operand = '0;
        endcase
        step_res = use_xor ? (r_hash ^ operand) : (r_hash + operand);
    end

    always_comb begin
        n_state          = r_state;
        n_step           = r_step;
        n_hash           = r_hash;
        div_req.start    = 1'b0;
        div_req.dividend = r_hash;
        div_req.divisor  = r_slots;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.byte_valid) begin
                        n_step  = STEP_ADD_BYTE;
                        n_state = S_MIX;
                    end else if (i_in.last_byte) begin
                        n_step  = STEP_FIN_SHLA;
                        n_state = S_MIX;
                    end
                end
            end
            S_MIX: begin
                n_hash = step_res;
                n_step = r_step + 1'b1;
                if (r_step == STEP_MIX_SHR && !r_last) begin
                    n_state = S_IDLE;
                end else if (r_step == STEP_FIN_SHLB) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                div_req.start = 1'b1;
                n_hash        = '0;
                n_state       = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    oaat_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_ADD_BYTE;
            r_hash  <= '0;
            r_slots <= SLOTS_RESET;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_hash  <= n_hash;
            if (i_cfg_we) begin
                r_slots <= i_cfg_wdata;
            end
            if (r_state == S_PUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_in.key_byte;
            r_last <= i_in.last_byte;
        end
        if (r_state == S_PUT && out_free) begin
            // A zero slot count maps every key to bucket 0.
            r_bucket <= (r_slots == '0) ? '0 : div_rsp.rem;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.bucket_index = r_bucket;

endmodule

FILE: sv/oaat_checker.sv
// Port-level checker for the bucket hash block, bound to the top level.
// Depends on the assertion macros header and the top level's channel ports.
`include "one_at_a_time_hash_bucket_macros.svh"

module oaat_checker import oaat_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_byte_valid,
    input logic              i_in_last_byte,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [SLOT_W-1:0] i_out_bucket
);

    logic in_acc;
    logic out_stall;
    logic carries_work;

    assign in_acc       = i_in_valid && i_in_ready;
    assign out_stall    = i_out_valid && !i_out_ready;
    assign carries_work = i_in_byte_valid || i_in_last_byte;

    // A stalled result item holds its value.
    `OAAT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_out_bucket))

    // An item that carries a byte or ends a key keeps the block busy next cycle.
    `OAAT_ASSERT_NXT(a_busy_after_work, i_clk, i_rst_n, in_acc && carries_work, !i_in_ready)

    // An empty item that does not end a key is absorbed in its accept cycle.
    `OAAT_ASSERT_NXT(a_empty_item, i_clk, i_rst_n, in_acc && !carries_work, i_in_ready)

    // A new result only appears at the end of a busy stretch.
    `OAAT_ASSERT_IMP(a_result_after_busy, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready))

endmodule

bind one_at_a_time_hash_bucket oaat_checker u_oaat_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_byte_valid (i_in.byte_valid),
    .i_in_last_byte  (i_in.last_byte),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_bucket    (o_out.bucket_index)
);

FILE: dv/tb_one_at_a_time_hash_bucket.sv
// Testbench of the one-at-a-time bucket hash block: keys are streamed in one byte
// per item and each bucket index is checked against a predictor kept in this file.
// Depends on oaat_pkg, the channel interfaces of oaat_if.sv and the block's top level.
module tb_one_at_a_time_hash_bucket import oaat_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam int SEGMENTS     = 9;
    localparam int SEG_ITEMS    = 194;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] key_byte;
        logic              byte_valid;
        logic              last_byte;
    } t_key_item;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SLOT_W-1:0] i_cfg_wdata;

    oaat_in_if  in_if ();
    oaat_out_if out_if ();

    one_at_a_time_hash_bucket u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    t_key_item         key_items[$];
    logic [SLOT_W-1:0] bucket_expected[$];
    logic [HASH_W-1:0] hash_acc;
    logic [SLOT_W-1:0] slot_count;
    int                n_pushed;
    int                n_accepted;
    int                n_errors;
    int                stall_cycles;
    int                src_idle_pct;
    int                snk_idle_pct;
    bit                in_taken;

    always #1ns i_clk = ~i_clk;

    // Folds one accepted item into the running hash and, on the last item of a
    // key, finalizes it and queues the bucket index the block has to return.
    task automatic hash_key_item(input t_key_item item);
        logic [HASH_W-1:0] h;
        if (item.byte_valid) begin
            h = hash_acc + HASH_W'(item.key_byte);
            h = h + (h << 10);
            h = h ^ (h >> 6);
            hash_acc = h;
        end
        if (item.last_byte) begin
            h = hash_acc;
            h = h + (h << 3);
            h = h ^ (h >> 11);
            h = h + (h << 15);
            hash_acc = '0;
            if (slot_count == '0) begin
                bucket_expected.push_back('0);
            end else begin
                bucket_expected.push_back(SLOT_W'(h % {32'd0, slot_count}));
            end
        end
    endtask

    task automatic push_item(input logic [BYTE_W-1:0] b, input logic v, input logic l);
        key_items.push_back(t_key_item'{b, v, l});
        n_pushed++;
    endtask

    // Mostly short keys, now and then a long one; ignored items are mixed in and
    // some keys end on an item that carries no byte.
    task automatic push_random_key(output int counted);
        int len;
        int k;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        counted = 0;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(99) < 8) begin
                push_item(BYTE_W'($urandom), 1'b0, 1'b0);
                counted++;
            end
            if (k == len - 1 && $urandom_range(9) == 0) begin
                push_item(BYTE_W'($urandom), 1'b0, 1'b1);
            end else begin
                push_item(BYTE_W'($urandom), 1'b1, k == len - 1);
            end
            counted++;
        end
    endtask

    // Waits until every item is taken and every result is back, then gives the
    // block time to finish an item that has no result.
    task automatic settle_block();
        while (!(n_accepted == n_pushed && bucket_expected.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slots(input logic [SLOT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        slot_count = value;
    endtask

    // Sender side: a new item is presented once the previous one has been taken; the sink's ready is drawn at random.
    always @(negedge i_clk) begin
        t_key_item nxt;
        if (i_rst_n && (!in_if.valid || in_taken)) begin
            in_taken = 1'b0;
            if (key_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = key_items.pop_front();
                in_if.valid      <= 1'b1;
                in_if.key_byte   <= nxt.key_byte;
                in_if.byte_valid <= nxt.byte_valid;
                in_if.last_byte  <= nxt.last_byte;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        logic              progress;
        logic [SLOT_W-1:0] want;
        progress = 1'b0;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                hash_key_item(t_key_item'{in_if.key_byte, in_if.byte_valid, in_if.last_byte});
                in_taken = 1'b1;
                n_accepted++;
                progress = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                progress = 1'b1;
                if (bucket_expected.size() == 0) begin
                    n_errors++;
                    if (n_errors <= SHOWN_ERRORS) begin
                        $display("unexpected bucket index %0d", out_if.bucket_index);
                    end
                end else begin
                    want = bucket_expected.pop_front();
                    if (out_if.bucket_index !== want) begin
                        n_errors++;
                        if (n_errors <= SHOWN_ERRORS) begin
                            $display("bucket index mismatch: expected %0d, got %0d",
                                     want, out_if.bucket_index);
                        end
                    end
                end
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [SLOT_W-1:0] slot_plan [SEGMENTS];
        int                seg;
        int                counted;
        int                got;

        slot_plan = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd7, 32'h8000_0000,
                      32'd1000003, 32'd1024, 32'hFFFF_FFFE, 32'd2};
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_if.valid      = 1'b0;
        in_if.key_byte   = '0;
        in_if.byte_valid = 1'b0;
        in_if.last_byte  = 1'b0;
        out_if.ready     = 1'b0;
        hash_acc         = '0;
        slot_count       = 32'd1024;
        n_pushed         = 0;
        n_accepted       = 0;
        n_errors         = 0;
        stall_cycles     = 0;
        src_idle_pct     = 8;
        snk_idle_pct     = 73;
        in_taken         = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed keys at the reset slot count: empty keys, single extreme
        // bytes, ignored items before and inside a key, and a key that ends
        // on an item without a byte.
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'h61, 1'b1, 1'b1);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h5A, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        for (int k = 0; k < 8; k++) begin
            push_item(8'hFF, 1'b1, k == 7);
        end
        for (int k = 0; k < 3; k++) begin
            push_item(8'h00, 1'b1, 1'b0);
        end
        push_item(8'h80, 1'b0, 1'b1);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            settle_block();
            if (seg < 3) begin
                src_idle_pct = 8;
                snk_idle_pct = 73;
            end else if (seg < 6) begin
                src_idle_pct = 73;
                snk_idle_pct = 8;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_slots(seg == 5 ? SLOT_W'($urandom) : slot_plan[seg]);
            counted = 0;
            while (counted < SEG_ITEMS) begin
                if ($urandom_range(19) == 0) begin
                    push_item(BYTE_W'($urandom), 1'b0, 1'b1);
                    counted++;
                end else begin
                    push_random_key(got);
                    counted += got;
                end
            end
        end

        settle_block();
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
